[rtl/core/ipdd_pkg.sv]
package ipdd_pkg;

  localparam int unsigned KeyW      = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned BitsW     = 6;
  localparam int unsigned TimeW     = 16;
  localparam int unsigned CfgIdxW   = 2;

  localparam int unsigned MaxIntervalsDefault = 256;

  // Register indexes on the configuration channel.
  localparam logic [CfgIdxW-1:0] RegHeaderMin  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSkipMin    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBitSplit   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegEndTimeout = 2'd3;

  // Reset values of the registers.
  localparam logic [TimeW-1:0] HeaderMinReset  = 16'd4000;
  localparam logic [TimeW-1:0] SkipMinReset    = 16'd500;
  localparam logic [TimeW-1:0] BitSplitReset   = 16'd940;
  localparam logic [TimeW-1:0] EndTimeoutReset = 16'd8000;

  // Frame status codes.
  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusNoHeader = 2'd1;
  localparam logic [StatusW-1:0] StatusSkipErr  = 2'd2;

  localparam logic [BitsW-1:0] MaxKeyBits = 6'd32;

  typedef struct packed {
    logic [KeyW-1:0]    decoded_key;
    logic [StatusW-1:0] frame_status;
    logic [BitsW-1:0]   bits_received;
  } ipdd_result_t;

endpackage

[rtl/core/ipdd_if.sv]
interface ipdd_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

interface ipdd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ipdd_pkg::KeyW-1:0]    decoded_key;
  logic [ipdd_pkg::StatusW-1:0] frame_status;
  logic [ipdd_pkg::BitsW-1:0]   bits_received;

  modport source (output valid, output decoded_key, output frame_status,
                  output bits_received, input ready);
  modport sink (input valid, input decoded_key, input frame_status,
                input bits_received, output ready);
endinterface

interface ipdd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ipdd_pkg::CfgIdxW-1:0] index;
  logic [ipdd_pkg::TimeW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/ir_pulse_distance_decoder.sv]
// Channel   Direction  Payload                                        Request taken when
// in_if     sink       pin_level                                      valid && ready
// out_if    source     decoded_key, frame_status, bits_received       valid && ready
// cfg_if    sink       index (0..3), data (16 bit)                    valid && ready
//
// One pin sample is taken per clock cycle while input ready is high; a sample is folded
// into the frame state in the cycle it is accepted, and a finished frame's result is
// stored in the output or skid register. One pass of short compare logic sets the rate.
// Reset loads the register defaults and leaves the decoder idle with no result pending.
// A two-entry output queue (output register plus skid register) lets input requests
// continue while a result waits; input ready drops only when both entries are full.
module ir_pulse_distance_decoder
  #(parameter int unsigned MaxIntervals = ipdd_pkg::MaxIntervalsDefault)
  (input  logic clk_i,
   input  logic rst_ni,
   ipdd_in_if.sink     in_if,
   ipdd_out_if.source  out_if,
   ipdd_cfg_if.sink    cfg_if);

  import ipdd_pkg::*;

  // The interval index counts up to MaxIntervals itself.
  localparam int unsigned IdxW = $clog2(MaxIntervals + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(MaxIntervals);

  // Configuration registers.
  logic [TimeW-1:0] header_min_q, skip_min_q, bit_split_q, end_timeout_q;

  // Frame state.
  logic             receiving_q, receiving_d;
  logic             exp_level_q, exp_level_d;
  logic [TimeW-1:0] ticks_q, ticks_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             header_q, header_d;
  logic             skip_err_q, skip_err_d;
  logic             skip_bad_q, skip_bad_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [BitsW-1:0] bits_q, bits_d;

  // Output queue.
  ipdd_result_t out_q, out_d, skid_q, skid_d, res;
  logic         out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic in_fire, out_fire, res_valid, finish;
  logic [TimeW-1:0] d;
  logic [IdxW-1:0]  idx_inc;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = !skid_valid_q;
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_fire     = out_valid_q && out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_min_q  <= HeaderMinReset;
      skip_min_q    <= SkipMinReset;
      bit_split_q   <= BitSplitReset;
      end_timeout_q <= EndTimeoutReset;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        RegHeaderMin:  header_min_q  <= cfg_if.data;
        RegSkipMin:    skip_min_q    <= cfg_if.data;
        RegBitSplit:   bit_split_q   <= cfg_if.data;
        RegEndTimeout: end_timeout_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Frame decoding for one accepted sample.
  always_comb begin
    receiving_d = receiving_q;
    exp_level_d = exp_level_q;
    ticks_d     = ticks_q;
    idx_d       = idx_q;
    header_d    = header_q;
    skip_err_d  = skip_err_q;
    skip_bad_d  = skip_bad_q;
    key_d       = key_q;
    bits_d      = bits_q;
    finish      = 1'b0;
    d           = ticks_q;
    idx_inc     = idx_q + IdxW'(1);

    if (!receiving_q) begin
      if (!in_if.pin_level) begin
        // First low sample opens a frame.
        receiving_d = 1'b1;
        exp_level_d = 1'b0;
        ticks_d     = TimeW'(1);
        idx_d       = '0;
        header_d    = 1'b0;
        skip_err_d  = 1'b0;
        skip_bad_d  = 1'b0;
        key_d       = '0;
        bits_d      = '0;
        finish      = (TimeW'(1) >= end_timeout_q);
      end
    end else if (in_if.pin_level == exp_level_q) begin
      if (ticks_q != {TimeW{1'b1}}) begin
        ticks_d = ticks_q + TimeW'(1);
      end
      finish = (ticks_d >= end_timeout_q);
    end else begin
      // Level changed: the interval just ended is classified by its position.
      if (idx_q == '0) begin
        header_d = (d > header_min_q);
      end else if (idx_q == IdxW'(1)) begin
        header_d = header_q && (d > header_min_q);
      end else if (!idx_q[0]) begin
        skip_bad_d = !(d > skip_min_q);
      end else if (header_q && !skip_err_q) begin
        if (skip_bad_q) begin
          skip_err_d = 1'b1;
        end else if (bits_q < MaxKeyBits) begin
          if (d > bit_split_q) begin
            key_d = key_q | (KeyW'(1) << bits_q[4:0]);
          end
          bits_d = bits_q + BitsW'(1);
        end
      end
      idx_d = idx_inc;
      if (idx_inc == IdxLast) begin
        finish = 1'b1;
      end else begin
        exp_level_d = in_if.pin_level;
        ticks_d     = TimeW'(1);
        finish      = (TimeW'(1) >= end_timeout_q);
      end
    end

    if (finish) begin
      receiving_d = 1'b0;
    end

    // Result built from the updated frame state.
    res.decoded_key   = '0;
    res.bits_received = '0;
    if ((idx_d < IdxW'(2)) || !header_d) begin
      res.frame_status = StatusNoHeader;
    end else if (skip_err_d) begin
      res.frame_status  = StatusSkipErr;
      res.bits_received = bits_d;
    end else begin
      res.frame_status  = StatusOk;
      res.decoded_key   = key_d;
      res.bits_received = bits_d;
    end
  end

  assign res_valid = in_fire && finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      exp_level_q <= 1'b0;
      ticks_q     <= '0;
      idx_q       <= '0;
      header_q    <= 1'b0;
      skip_err_q  <= 1'b0;
      skip_bad_q  <= 1'b0;
      key_q       <= '0;
      bits_q      <= '0;
    end else if (in_fire) begin
      receiving_q <= receiving_d;
      exp_level_q <= exp_level_d;
      ticks_q     <= ticks_d;
      idx_q       <= idx_d;
      header_q    <= header_d;
      skip_err_q  <= skip_err_d;
      skip_bad_q  <= skip_bad_d;
      key_q       <= key_d;
      bits_q      <= bits_d;
    end
  end

  // Output register with a skid entry behind it.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (res_valid) begin
      if (!out_valid_d) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.decoded_key   = out_q.decoded_key;
  assign out_if.frame_status  = out_q.frame_status;
  assign out_if.bits_received = out_q.bits_received;

endmodule

[tb/sv/tb_ir_pulse_distance_decoder.sv]
module tb_ir_pulse_distance_decoder;
  import ipdd_pkg::*;

  // One pin sample request as it waits in the driver queue. The gap is the
  // number of idle cycles the driver spends before it offers the sample.
  typedef struct {
    logic        level;
    int unsigned gap;
  } pin_req_t;

  logic clk;
  logic rst_n;

  ipdd_in_if  pin_if ();
  ipdd_out_if frame_if ();
  ipdd_cfg_if reg_if ();

  ir_pulse_distance_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (pin_if),
    .out_if (frame_if),
    .cfg_if (reg_if)
  );

  // Driver side: pin samples still to be offered, plus the idle settings that
  // the stimulus code switches between frames.
  pin_req_t    pin_q[$];
  pin_req_t    next_req;
  int unsigned pin_wait;
  logic        pin_taken;
  int unsigned gen_gap_max;
  int unsigned gen_items;

  // Receiver side stall control.
  logic        res_taken;
  int unsigned res_stall;
  int unsigned res_stall_max;

  // Timing values the stimulus code shapes its intervals around. They mirror
  // the registers but are only used to generate pulses, never to predict.
  int unsigned gen_hdr;
  int unsigned gen_skip;
  int unsigned gen_split;
  int unsigned gen_tmo;

  // Decoder prediction: register copy and frame state.
  logic [TimeW-1:0]  hdr_min;
  logic [TimeW-1:0]  skip_min;
  logic [TimeW-1:0]  split_thr;
  logic [TimeW-1:0]  tmo_cfg;
  logic              rx_active;
  logic              rx_level;
  logic [TimeW-1:0]  run_len;
  int unsigned       ivl_count;
  logic              hdr_ok;
  logic              skip_fail;
  logic              skip_bad_last;
  logic [KeyW-1:0]   key_acc;
  logic [BitsW-1:0]  key_bits;

  // Frames the decoder still owes us, oldest first.
  ipdd_result_t pending_frames[$];

  int unsigned samples_taken;
  int unsigned frames_checked;
  int unsigned mismatches;
  int unsigned n_ok;
  int unsigned n_nohdr;
  int unsigned n_skip;
  int unsigned cap_hits;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // A completed interval of d ticks. Intervals 0 and 1 form the header; after
  // that even intervals are the low skips and odd ones the high bit periods.
  // A bad skip only turns into an error once the high period after it has
  // completed, so a trailing mark that runs into the timeout is harmless.
  function automatic void close_interval(input logic [TimeW-1:0] d);
    if (ivl_count == 0) begin
      hdr_ok = (d > hdr_min);
    end else if (ivl_count == 1) begin
      hdr_ok = hdr_ok && (d > hdr_min);
    end else if (ivl_count % 2 == 0) begin
      skip_bad_last = !(d > skip_min);
    end else if (hdr_ok && !skip_fail) begin
      if (skip_bad_last) begin
        skip_fail = 1'b1;
      end else if (key_bits < MaxKeyBits) begin
        // Bits beyond the 32nd are silently dropped.
        if (d > split_thr) key_acc[key_bits] = 1'b1;
        key_bits++;
      end
    end
    ivl_count++;
  endfunction

  // The frame is over: queue the result the decoder must produce and go idle.
  // The key and bit count are only reported as far as the status allows.
  function automatic void close_frame();
    ipdd_result_t res;
    res = '0;
    if (ivl_count < 2 || !hdr_ok) begin
      res.frame_status = StatusNoHeader;
      n_nohdr++;
    end else if (skip_fail) begin
      res.frame_status  = StatusSkipErr;
      res.bits_received = key_bits;
      n_skip++;
    end else begin
      res.frame_status  = StatusOk;
      res.decoded_key   = key_acc;
      res.bits_received = key_bits;
      n_ok++;
    end
    pending_frames.push_back(res);
    rx_active = 1'b0;
  endfunction

  // Fold one accepted pin sample into the predicted decoder state.
  function automatic void decode_sample(input logic level);
    if (!rx_active) begin
      // Idle: a high line is ignored, the first low sample opens a frame.
      if (!level) begin
        rx_active     = 1'b1;
        rx_level      = 1'b0;
        run_len       = TimeW'(1);
        ivl_count     = 0;
        hdr_ok        = 1'b0;
        skip_fail     = 1'b0;
        skip_bad_last = 1'b0;
        key_acc       = '0;
        key_bits      = '0;
      end
    end else if (level == rx_level) begin
      if (run_len != {TimeW{1'b1}}) run_len++;
    end else begin
      close_interval(run_len);
      if (ivl_count >= MaxIntervalsDefault) begin
        // The interval cap ends the frame; the new level is not timed at all.
        close_frame();
        cap_hits++;
      end else begin
        rx_level = level;
        run_len  = TimeW'(1);
      end
    end
    // A level held for the end timeout closes the frame. The unfinished
    // interval is dropped, which is why a timeout of one ends a frame on the
    // very sample that opened it.
    if (rx_active && run_len >= tmo_cfg) close_frame();
  endfunction

  // Compare one accepted result with the oldest outstanding prediction.
  function automatic void check_frame();
    ipdd_result_t want;
    if (pending_frames.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected frame: key %h status %0d bits %0d", frame_if.decoded_key,
                 frame_if.frame_status, frame_if.bits_received);
    end else begin
      want = pending_frames.pop_front();
      if (frame_if.decoded_key !== want.decoded_key ||
          frame_if.frame_status !== want.frame_status ||
          frame_if.bits_received !== want.bits_received) begin
        mismatches++;
        if (mismatches <= 10)
          $display("frame %0d mismatch: key %h/%h status %0d/%0d bits %0d/%0d (exp/got)",
                   frames_checked, want.decoded_key, frame_if.decoded_key,
                   want.frame_status, frame_if.frame_status,
                   want.bits_received, frame_if.bits_received);
      end
      frames_checked++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------------

  // Pin sample driver. A request stays on the bus until it is taken; after
  // that the next sample is offered once its own idle gap has run out.
  always @(negedge clk) begin
    if (!rst_n) begin
      pin_if.valid <= 1'b0;
      pin_wait = 0;
    end else if (!pin_if.valid || pin_taken) begin
      if (pin_q.size() == 0) begin
        pin_if.valid <= 1'b0;
      end else if (pin_wait < pin_q[0].gap) begin
        pin_if.valid <= 1'b0;
        pin_wait++;
      end else begin
        next_req = pin_q.pop_front();
        pin_if.valid     <= 1'b1;
        pin_if.pin_level <= next_req.level;
        pin_wait = 0;
      end
    end
  end

  // Result receiver. After every result it takes, it stalls for a freshly
  // drawn number of cycles before raising ready again.
  always @(negedge clk) begin
    if (!rst_n) begin
      frame_if.ready <= 1'b0;
      res_stall = 0;
    end else begin
      if (res_taken) res_stall = $urandom_range(0, res_stall_max);
      if (res_stall != 0) begin
        frame_if.ready <= 1'b0;
        res_stall--;
      end else begin
        frame_if.ready <= 1'b1;
      end
    end
  end

  // Monitor. The result check runs before the prediction of the sample taken
  // on the same edge, because that sample can only affect later results.
  always @(posedge clk) begin
    if (!rst_n) begin
      pin_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      pin_taken <= pin_if.valid && pin_if.ready;
      res_taken <= frame_if.valid && frame_if.ready;
      if (frame_if.valid && frame_if.ready) check_frame();
      if (pin_if.valid && pin_if.ready) begin
        samples_taken++;
        decode_sample(pin_if.pin_level);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queue n samples of one level, each with its own idle gap.
  task automatic push_run(input logic lvl, input int unsigned n);
    pin_req_t req;
    for (int unsigned k = 0; k < n; k++) begin
      req.level = lvl;
      req.gap   = $urandom_range(0, gen_gap_max);
      pin_q.push_back(req);
      gen_items++;
    end
  endtask

  // Queue a literal pattern of samples, one character per tick.
  task automatic push_pattern(input string pat);
    for (int k = 0; k < pat.len(); k++) push_run(pat.getc(k) == "1", 1);
  endtask

  // An interval length either just above a threshold or at or below it. It is
  // kept under the end timeout so that the interval really completes.
  function automatic int unsigned pick_len(input int unsigned thr, input bit above);
    int unsigned n;
    if (above || thr == 0) n = thr + 1 + $urandom_range(0, 2);
    else n = $urandom_range(1, thr);
    if (n >= gen_tmo) n = (gen_tmo > 1) ? gen_tmo - 1 : 1;
    return n;
  endfunction

  // A well formed frame with random content: header, a few bits and an
  // ending that is either a trailing mark or a low line held to the timeout.
  // Now and then the header or a skip is made too short.
  task automatic push_coded_frame();
    int unsigned nbits;
    nbits = $urandom_range(0, 8);
    push_run(1'b0, pick_len(gen_hdr, $urandom_range(0, 7) != 0));
    push_run(1'b1, pick_len(gen_hdr, $urandom_range(0, 7) != 0));
    repeat (nbits) begin
      push_run(1'b0, pick_len(gen_skip, $urandom_range(0, 15) != 0));
      push_run(1'b1, pick_len(gen_split, $urandom_range(0, 1) != 0));
    end
    if ($urandom_range(0, 1)) begin
      push_run(1'b0, pick_len(gen_skip, $urandom_range(0, 3) != 0));
      push_run(1'b1, gen_tmo);
    end else begin
      push_run(1'b0, gen_tmo);
    end
  endtask

  // Line noise: runs of random level and length, then a low hold that is sure
  // to close whatever frame the noise opened.
  task automatic push_noise();
    repeat ($urandom_range(1, 20))
      push_run(1'($urandom_range(0, 1)), $urandom_range(1, gen_tmo + 1));
    push_run(1'b0, gen_tmo);
  endtask

  // A frame of single-tick spaces and one- or two-tick marks that runs into
  // the interval cap. Far more bits arrive than the key holds, so the later
  // ones must be dropped. Meant for header and skip minimums of 0, a split
  // of 1 and a timeout above 2.
  task automatic push_cap_frame();
    for (int unsigned k = 0; k <= MaxIntervalsDefault; k++)
      push_run(k[0], (k[0] && $urandom_range(0, 1) != 0) ? 2 : 1);
  endtask

  // Hold back new samples until every queued sample has been taken and every
  // predicted frame has arrived, then give the output path time to settle.
  task automatic drain();
    do @(posedge clk);
    while (pin_q.size() != 0 || pin_if.valid || pending_frames.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic void pick_idle_mode();
    gen_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 19;
    res_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] val);
    @(negedge clk);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= val;
    do @(posedge clk);
    while (!reg_if.ready);
    case (idx)
      RegHeaderMin:  hdr_min   = val;
      RegSkipMin:    skip_min  = val;
      RegBitSplit:   split_thr = val;
      RegEndTimeout: tmo_cfg   = val;
      default: ;
    endcase
  endtask

  // Reprogram all four timing registers once the decoder has gone quiet.
  task automatic set_timing(input int unsigned h, input int unsigned s,
                            input int unsigned b, input int unsigned t);
    drain();
    write_reg(RegHeaderMin, TimeW'(h));
    write_reg(RegSkipMin, TimeW'(s));
    write_reg(RegBitSplit, TimeW'(b));
    write_reg(RegEndTimeout, TimeW'(t));
    @(negedge clk);
    reg_if.valid <= 1'b0;
    gen_hdr   = h;
    gen_skip  = s;
    gen_split = b;
    gen_tmo   = t;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned h;
    int unsigned s;
    int unsigned b;
    int unsigned t;
    int unsigned top;
    int unsigned start_items;

    rst_n            = 1'b0;
    pin_if.valid     = 1'b0;
    pin_if.pin_level = 1'b1;
    frame_if.ready   = 1'b0;
    reg_if.valid     = 1'b0;
    reg_if.index     = RegHeaderMin;
    reg_if.data      = '0;
    pin_taken        = 1'b0;
    res_taken        = 1'b0;
    gen_items        = 0;
    samples_taken    = 0;
    frames_checked   = 0;
    mismatches       = 0;
    n_ok             = 0;
    n_nohdr          = 0;
    n_skip           = 0;
    cap_hits         = 0;
    hdr_min          = HeaderMinReset;
    skip_min         = SkipMinReset;
    split_thr        = BitSplitReset;
    tmo_cfg          = EndTimeoutReset;
    rx_active        = 1'b0;
    rx_level         = 1'b0;
    run_len          = '0;
    ivl_count        = 0;
    hdr_ok           = 1'b0;
    skip_fail        = 1'b0;
    skip_bad_last    = 1'b0;
    key_acc          = '0;
    key_bits         = '0;
    gen_hdr          = HeaderMinReset;
    gen_skip         = SkipMinReset;
    gen_split        = BitSplitReset;
    gen_tmo          = EndTimeoutReset;
    gen_gap_max      = 0;
    res_stall_max    = 19;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A high line out of reset must leave the decoder idle and silent.
    push_run(1'b1, 16);

    // Timeout of one: every low sample opens and at once closes a frame.
    set_timing(1, 1, 1, 1);
    gen_gap_max = 19;
    push_pattern("1001");

    // Short hand-built frames: a skip failure after one zero bit, a trailing
    // mark whose bad skip must be ignored, and a frame with no header.
    set_timing(1, 1, 1, 3);
    push_pattern("001100101000");
    push_pattern("00110111");
    push_pattern("0111");

    // One frame long enough to overflow the key and hit the interval cap.
    set_timing(0, 0, 1, 3);
    push_cap_frame();

    // Random frames under a series of settings. The first few pin the
    // thresholds at their extremes: all open, all closed, skips that can
    // never pass, and bits that can never be ones.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_timing(0, 0, 0, $urandom_range(4, 8));
        1: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 7);
        2: set_timing(2, 16'hFFFF, 3, 9);
        3: set_timing(2, 1, 16'hFFFF, 9);
        default: begin
          h = $urandom_range(0, 8);
          s = $urandom_range(0, 4);
          b = $urandom_range(0, 6);
          top = (h > s) ? h : s;
          if (b > top) top = b;
          t = top + 4 + $urandom_range(0, 4);
          set_timing(h, s, b, t);
        end
      endcase
      pick_idle_mode();
      start_items = gen_items;
      while (gen_items - start_items < 50) begin
        if ($urandom_range(0, 4) == 0) push_noise();
        else push_coded_frame();
        // Occasionally the sender waits for every result to come back.
        if ($urandom_range(0, 9) == 0) begin
          drain();
          pick_idle_mode();
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (pending_frames.size() != 0) mismatches++;

    $display("summary: %0d pin samples, %0d frames checked (%0d ok, %0d no header, %0d skip error)",
             samples_taken, frames_checked, n_ok, n_nohdr, n_skip);
    $display("summary: thresholds swept from 0 to 65535, short end timeouts, cap hit %0d times",
             cap_hits);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
